/* sv/clcd_pkg.sv */
`default_nettype none

package clcd_pkg;

  // Field widths fixed by the request and transfer formats.
  localparam int unsigned CmdW       = 4;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SettleW    = 16;
  localparam int unsigned LineColW   = 6;
  localparam int unsigned RowClampW  = 3;
  localparam int unsigned CfgIndexW  = 4;
  localparam int unsigned InitStepW  = 4;

  // Size limits and fallbacks.
  localparam int unsigned MaxColumnsDef = 40;
  localparam int unsigned MaxRowsDef    = 4;
  localparam int unsigned JobDepthDef   = 2;
  localparam int unsigned RspDepthDef   = 2;
  localparam logic [LineColW-1:0]  FallbackCols = 6'd16;
  localparam logic [RowClampW-1:0] FallbackRows = 3'd2;
  localparam logic [ByteW-1:0]     ResetCols    = 8'd16;
  localparam logic [ByteW-1:0]     ResetRows    = 8'd2;

  // Configuration register indexes.
  localparam logic [CfgIndexW-1:0] RegColumns = 4'd0;
  localparam logic [CfgIndexW-1:0] RegRows    = 4'd1;

  // Display command bytes and nibbles.
  localparam logic [ByteW-1:0] ByteFuncSet   = 8'h28;
  localparam logic [ByteW-1:0] ByteDispOn    = 8'h0C;
  localparam logic [ByteW-1:0] ByteDispOff   = 8'h08;
  localparam logic [ByteW-1:0] ByteClear     = 8'h01;
  localparam logic [ByteW-1:0] ByteHome      = 8'h02;
  localparam logic [ByteW-1:0] ByteEntryMode = 8'h06;
  localparam logic [ByteW-1:0] ByteSpace     = 8'h20;
  localparam logic [ByteW-1:0] NibbleWake    = 8'h03;
  localparam logic [ByteW-1:0] NibbleFour    = 8'h02;

  // Settle times in microseconds.
  localparam logic [SettleW-1:0] SettlePowerUp = 16'd50000;
  localparam logic [SettleW-1:0] SettleLong    = 16'd5000;
  localparam logic [SettleW-1:0] SettleShort   = 16'd2000;
  localparam logic [SettleW-1:0] SettleNibble  = 16'd150;

  // Init runs nine transfers, steps zero through eight.
  localparam logic [InitStepW-1:0] InitLastStep = 4'd8;

  typedef enum logic [CmdW-1:0] {
    CMD_INIT       = 4'd0,
    CMD_CLEAR      = 4'd1,
    CMD_ON         = 4'd2,
    CMD_OFF        = 4'd3,
    CMD_SET_CURSOR = 4'd4,
    CMD_PUT_CHAR   = 4'd5,
    CMD_LINE_BEGIN = 4'd6,
    CMD_LINE_CHAR  = 4'd7,
    CMD_LINE_END   = 4'd8
  } cmd_e;

  typedef enum logic [1:0] {
    XFER_WAIT   = 2'd0,
    XFER_NIBBLE = 2'd1,
    XFER_BYTE   = 2'd2
  } xfer_kind_e;

  typedef enum logic [1:0] {
    JOB_INIT = 2'd0,
    JOB_BYTE = 2'd1,
    JOB_PAD  = 2'd2
  } job_kind_e;

  typedef enum logic {
    BE_IDLE = 1'b0,
    BE_RUN  = 1'b1
  } be_state_e;

  typedef struct packed {
    logic [CmdW-1:0]  cmd;
    logic [ByteW-1:0] row_index;
    logic [ByteW-1:0] column_index;
    logic [ByteW-1:0] char_code;
  } req_t;

  typedef struct packed {
    logic [1:0]         transfer_kind;
    logic               reg_select;
    logic [ByteW-1:0]   bus_value;
    logic [SettleW-1:0] settle_us;
    logic               last_of_run;
  } rsp_t;

  // One classified request as handed from the front to the back.
  typedef struct packed {
    job_kind_e           kind;
    logic [ByteW-1:0]    value;
    logic                rs;
    logic [LineColW-1:0] count;
  } job_t;

  // Clear and home need the long settle time; all other bytes the short one.
  function automatic logic [SettleW-1:0] byte_settle(input logic [ByteW-1:0] value);
    logic [SettleW-1:0] settle;
    settle = ((value == ByteClear) || (value == ByteHome)) ? SettleLong : SettleShort;
    return settle;
  endfunction

  // Transfer for one step of the power-up sequence; last_of_run is left clear.
  function automatic rsp_t init_xfer(input logic [InitStepW-1:0] step);
    rsp_t x;
    x = '0;
    unique case (step)
      4'd0: begin
        x.transfer_kind = XFER_WAIT;
        x.settle_us     = SettlePowerUp;
      end
      4'd1: begin
        x.transfer_kind = XFER_NIBBLE;
        x.bus_value     = NibbleWake;
        x.settle_us     = SettleLong;
      end
      4'd2, 4'd3: begin
        x.transfer_kind = XFER_NIBBLE;
        x.bus_value     = NibbleWake;
        x.settle_us     = SettleNibble;
      end
      4'd4: begin
        x.transfer_kind = XFER_NIBBLE;
        x.bus_value     = NibbleFour;
        x.settle_us     = SettleNibble;
      end
      4'd5: begin
        x.transfer_kind = XFER_BYTE;
        x.bus_value     = ByteFuncSet;
      end
      4'd6: begin
        x.transfer_kind = XFER_BYTE;
        x.bus_value     = ByteDispOn;
      end
      4'd7: begin
        x.transfer_kind = XFER_BYTE;
        x.bus_value     = ByteClear;
      end
      4'd8: begin
        x.transfer_kind = XFER_BYTE;
        x.bus_value     = ByteEntryMode;
      end
      default: begin
        x = '0;
      end
    endcase
    if (x.transfer_kind == XFER_BYTE) begin
      x.settle_us = byte_settle(x.bus_value);
    end
    return x;
  endfunction

endpackage

`default_nettype wire

/* sv/char_lcd_4bit_command_sequencer.sv */
`default_nettype none

// Channel   Direction  Handshake                Payload
// request   in         push / full              req_i  (cmd, row, column, char)
// result    out        pop / empty              rsp_o  (kind, rs, value, settle, last)
// config    in         cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// A request is classified in the cycle it is accepted and queued as at most one job.
// The transfer engine loads a job while idle and then emits one transfer per cycle
// while the result queue has room, taking no new job until its last transfer is out.
// Reset restores 16 columns, 2 rows and line position zero; the queues start empty.
// Either side may stall: full rises when the job queue is full, and the engine
// waits while the result queue is full.
module char_lcd_4bit_command_sequencer #(
  parameter int unsigned MaxColumns = clcd_pkg::MaxColumnsDef,
  parameter int unsigned MaxRows    = clcd_pkg::MaxRowsDef,
  parameter int unsigned JobDepth   = clcd_pkg::JobDepthDef,
  parameter int unsigned RspDepth   = clcd_pkg::RspDepthDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push,
  output logic                                full,
  input  wire clcd_pkg::req_t                 req_i,
  output logic                                empty,
  input  wire logic                           pop,
  output clcd_pkg::rsp_t                      rsp_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [clcd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [clcd_pkg::ByteW-1:0]     cfg_data_i
);

  logic           accept;
  logic           job_push;
  logic           job_pop;
  logic           job_empty;
  clcd_pkg::job_t job_in, job_out;
  logic           rsp_push;
  logic           rsp_full;
  clcd_pkg::rsp_t rsp_in;

  assign accept = push && !full;

  clcd_front #(
    .MaxColumns (MaxColumns),
    .MaxRows    (MaxRows)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .req_i       (req_i),
    .job_push_o  (job_push),
    .job_o       (job_in),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  clcd_fifo #(
    .T     (clcd_pkg::job_t),
    .Depth (JobDepth)
  ) u_job_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (full),
    .pop_i   (job_pop),
    .data_o  (job_out),
    .empty_o (job_empty)
  );

  clcd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .rsp_full_i  (rsp_full),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp_in)
  );

  clcd_fifo #(
    .T     (clcd_pkg::rsp_t),
    .Depth (RspDepth)
  ) u_rsp_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .data_i  (rsp_in),
    .full_o  (rsp_full),
    .pop_i   (pop),
    .data_o  (rsp_o),
    .empty_o (empty)
  );

endmodule

`default_nettype wire

/* sv/clcd_fifo.sv */
`default_nettype none

module clcd_fifo #(
  parameter type         T     = logic,
  parameter int unsigned Depth = 2
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire T     data_i,
  output logic      full_o,
  input  wire logic pop_i,
  output T          data_o,
  output logic      empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  T                mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            push_ok;
  logic            pop_ok;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push_ok) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_ok) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    unique case ({push_ok, pop_ok})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

/* sv/clcd_front.sv */
`default_nettype none

module clcd_front #(
  parameter int unsigned MaxColumns = clcd_pkg::MaxColumnsDef,
  parameter int unsigned MaxRows    = clcd_pkg::MaxRowsDef
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // Request side.
  input  wire logic                           push_i,
  input  wire clcd_pkg::req_t                 req_i,
  output logic                                job_push_o,
  output clcd_pkg::job_t                      job_o,
  // Configuration writes.
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [clcd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [clcd_pkg::ByteW-1:0]     cfg_data_i
);

  logic [clcd_pkg::ByteW-1:0]     cols_q, rows_q;
  logic [clcd_pkg::LineColW-1:0]  line_col_q, line_col_d;
  logic [clcd_pkg::LineColW-1:0]  cols_eff;
  logic [clcd_pkg::RowClampW-1:0] rows_eff;
  logic [clcd_pkg::RowClampW-1:0] row_c;
  logic [clcd_pkg::ByteW-1:0]     col_in;
  logic [clcd_pkg::LineColW-1:0]  col_c;
  logic [6:0]                     ddram_addr;
  logic [clcd_pkg::ByteW-1:0]     cursor_byte;
  logic                           room_in_line;

  assign cfg_ready_o = 1'b1;

  // Effective display size, with fallback for out-of-range settings.
  always_comb begin
    if ((cols_q == '0) || (cols_q > clcd_pkg::ByteW'(MaxColumns))) begin
      cols_eff = clcd_pkg::FallbackCols;
    end else begin
      cols_eff = cols_q[clcd_pkg::LineColW-1:0];
    end
    if ((rows_q == '0) || (rows_q > clcd_pkg::ByteW'(MaxRows))) begin
      rows_eff = clcd_pkg::FallbackRows;
    end else begin
      rows_eff = rows_q[clcd_pkg::RowClampW-1:0];
    end
  end

  // Cursor address: clamp row and column, second-line base for any nonzero row.
  always_comb begin
    col_in = (req_i.cmd == clcd_pkg::CMD_LINE_BEGIN) ? '0 : req_i.column_index;
    if (req_i.row_index >= {5'b0, rows_eff}) begin
      row_c = rows_eff - clcd_pkg::RowClampW'(1);
    end else begin
      row_c = req_i.row_index[clcd_pkg::RowClampW-1:0];
    end
    if (col_in >= {2'b0, cols_eff}) begin
      col_c = cols_eff - clcd_pkg::LineColW'(1);
    end else begin
      col_c = col_in[clcd_pkg::LineColW-1:0];
    end
    ddram_addr  = (row_c == '0) ? {1'b0, col_c} : (7'h40 | {1'b0, col_c});
    cursor_byte = {1'b1, ddram_addr};
  end

  assign room_in_line = (line_col_q < cols_eff);

  // Classify the request into a job for the back end.
  always_comb begin
    job_push_o = 1'b0;
    job_o      = '{kind: clcd_pkg::JOB_BYTE, value: '0, rs: 1'b0, count: '0};
    line_col_d = line_col_q;
    unique case (req_i.cmd)
      clcd_pkg::CMD_INIT: begin
        job_push_o = push_i;
        job_o.kind = clcd_pkg::JOB_INIT;
      end
      clcd_pkg::CMD_CLEAR: begin
        job_push_o  = push_i;
        job_o.value = clcd_pkg::ByteClear;
      end
      clcd_pkg::CMD_ON: begin
        job_push_o  = push_i;
        job_o.value = clcd_pkg::ByteDispOn;
      end
      clcd_pkg::CMD_OFF: begin
        job_push_o  = push_i;
        job_o.value = clcd_pkg::ByteDispOff;
      end
      clcd_pkg::CMD_SET_CURSOR: begin
        job_push_o  = push_i;
        job_o.value = cursor_byte;
      end
      clcd_pkg::CMD_PUT_CHAR: begin
        job_push_o  = push_i;
        job_o.value = req_i.char_code;
        job_o.rs    = 1'b1;
      end
      clcd_pkg::CMD_LINE_BEGIN: begin
        job_push_o  = push_i;
        job_o.value = cursor_byte;
        line_col_d  = '0;
      end
      clcd_pkg::CMD_LINE_CHAR: begin
        // Characters past the right edge are dropped.
        if (room_in_line) begin
          job_push_o  = push_i;
          job_o.value = req_i.char_code;
          job_o.rs    = 1'b1;
          line_col_d  = line_col_q + clcd_pkg::LineColW'(1);
        end
      end
      clcd_pkg::CMD_LINE_END: begin
        // Pad the rest of the line with spaces.
        if (room_in_line) begin
          job_push_o  = push_i;
          job_o.kind  = clcd_pkg::JOB_PAD;
          job_o.value = clcd_pkg::ByteSpace;
          job_o.rs    = 1'b1;
          job_o.count = cols_eff - line_col_q;
          line_col_d  = cols_eff;
        end
      end
      default: begin
        job_push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q     <= clcd_pkg::ResetCols;
      rows_q     <= clcd_pkg::ResetRows;
      line_col_q <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == clcd_pkg::RegColumns)) begin
        cols_q <= cfg_data_i;
      end
      if (cfg_valid_i && (cfg_index_i == clcd_pkg::RegRows)) begin
        rows_q <= cfg_data_i;
      end
      if (push_i) begin
        line_col_q <= line_col_d;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/clcd_back.sv */
`default_nettype none

module clcd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  // Job queue side.
  input  wire logic           job_empty_i,
  input  wire clcd_pkg::job_t job_i,
  output logic                job_pop_o,
  // Result queue side.
  input  wire logic           rsp_full_i,
  output logic                rsp_push_o,
  output clcd_pkg::rsp_t      rsp_o
);

  clcd_pkg::be_state_e           state_q, state_d;
  clcd_pkg::job_t                job_q;
  logic [clcd_pkg::LineColW-1:0] cnt_q, cnt_d;
  logic                          last;
  logic                          emit;

  assign job_pop_o = (state_q == clcd_pkg::BE_IDLE) && !job_empty_i;
  assign emit      = (state_q == clcd_pkg::BE_RUN) && !rsp_full_i;

  // Which transfer of the current job is the final one.
  always_comb begin
    unique case (job_q.kind)
      clcd_pkg::JOB_INIT: last = (cnt_q[clcd_pkg::InitStepW-1:0] == clcd_pkg::InitLastStep);
      clcd_pkg::JOB_PAD:  last = (cnt_q == clcd_pkg::LineColW'(1));
      default:            last = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      clcd_pkg::BE_IDLE: begin
        if (!job_empty_i) begin
          state_d = clcd_pkg::BE_RUN;
        end
      end
      clcd_pkg::BE_RUN: begin
        if (emit && last) begin
          state_d = clcd_pkg::BE_IDLE;
        end
      end
      default: state_d = clcd_pkg::BE_IDLE;
    endcase
  end

  // Transfer generation: init counts its step up, padding counts down.
  always_comb begin
    rsp_push_o = emit;
    cnt_d      = cnt_q;
    unique case (job_q.kind)
      clcd_pkg::JOB_INIT: begin
        rsp_o = clcd_pkg::init_xfer(cnt_q[clcd_pkg::InitStepW-1:0]);
      end
      default: begin
        rsp_o.transfer_kind = clcd_pkg::XFER_BYTE;
        rsp_o.reg_select    = job_q.rs;
        rsp_o.bus_value     = job_q.value;
        rsp_o.settle_us     = clcd_pkg::byte_settle(job_q.value);
        rsp_o.last_of_run   = 1'b0;
      end
    endcase
    rsp_o.last_of_run = last;
    if (job_pop_o) begin
      cnt_d = (job_i.kind == clcd_pkg::JOB_PAD) ? job_i.count : '0;
    end else if (emit) begin
      cnt_d = (job_q.kind == clcd_pkg::JOB_PAD) ? cnt_q - clcd_pkg::LineColW'(1)
                                                : cnt_q + clcd_pkg::LineColW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= clcd_pkg::BE_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Job payload register.
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

endmodule

`default_nettype wire

/* bench/char_lcd_transfer_checker.sv */
module char_lcd_transfer_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           push_i,
  input  wire logic                           full_i,
  input  wire clcd_pkg::req_t                 req_i,
  input  wire logic                           empty_i,
  input  wire logic                           pop_i,
  input  wire clcd_pkg::rsp_t                 rsp_i,
  input  wire logic                           cfg_valid_i,
  input  wire logic                           cfg_ready_i,
  input  wire logic [clcd_pkg::CfgIndexW-1:0] cfg_index_i,
  input  wire logic [clcd_pkg::ByteW-1:0]     cfg_data_i,
  output int unsigned                         fail_count_o,
  output int unsigned                         pending_o
);

  // Set DDRAM address command and the start address of every row below the first.
  localparam logic [clcd_pkg::ByteW-1:0] CmdSetAddr = 8'h80;
  localparam logic [clcd_pkg::ByteW-1:0] RowOneBase = 8'h40;

  // Shadow copy of the display size and of the streamed line position.
  logic [clcd_pkg::ByteW-1:0]    shadow_cols;
  logic [clcd_pkg::ByteW-1:0]    shadow_rows;
  logic [clcd_pkg::LineColW-1:0] shadow_line_pos;

  // Transfers the block still owes, oldest first.
  clcd_pkg::rsp_t pending_xfers[$];
  int unsigned    mismatches;

  assign fail_count_o = mismatches;

  // Display width after the fallback for out-of-range settings.
  function automatic logic [clcd_pkg::ByteW-1:0] usable_cols();
    logic [clcd_pkg::ByteW-1:0] w;
    w = shadow_cols;
    if ((w == '0) || (w > clcd_pkg::ByteW'(clcd_pkg::MaxColumnsDef))) begin
      w = clcd_pkg::ResetCols;
    end
    return w;
  endfunction

  // Display height after the fallback for out-of-range settings.
  function automatic logic [clcd_pkg::ByteW-1:0] usable_rows();
    logic [clcd_pkg::ByteW-1:0] h;
    h = shadow_rows;
    if ((h == '0) || (h > clcd_pkg::ByteW'(clcd_pkg::MaxRowsDef))) begin
      h = clcd_pkg::ResetRows;
    end
    return h;
  endfunction

  function automatic clcd_pkg::rsp_t make_xfer(input clcd_pkg::xfer_kind_e kind,
                                               input logic rs,
                                               input logic [clcd_pkg::ByteW-1:0] value,
                                               input logic [clcd_pkg::SettleW-1:0] settle);
    clcd_pkg::rsp_t x;
    x.transfer_kind = kind;
    x.reg_select    = rs;
    x.bus_value     = value;
    x.settle_us     = settle;
    x.last_of_run   = 1'b0;
    return x;
  endfunction

  // A full byte; clear and home need the long settle time.
  function automatic clcd_pkg::rsp_t make_byte(input logic [clcd_pkg::ByteW-1:0] value,
                                               input logic rs);
    logic [clcd_pkg::SettleW-1:0] settle;
    settle = ((value == clcd_pkg::ByteClear) || (value == clcd_pkg::ByteHome)) ?
             clcd_pkg::SettleLong : clcd_pkg::SettleShort;
    return make_xfer(clcd_pkg::XFER_BYTE, rs, value, settle);
  endfunction

  // Cursor move with row and column clamped to the usable size.
  function automatic clcd_pkg::rsp_t make_cursor(input logic [clcd_pkg::ByteW-1:0] row,
                                                 input logic [clcd_pkg::ByteW-1:0] col);
    logic [clcd_pkg::ByteW-1:0] r;
    logic [clcd_pkg::ByteW-1:0] c;
    logic [clcd_pkg::ByteW-1:0] addr;
    r = row;
    c = col;
    if (r >= usable_rows()) begin
      r = usable_rows() - 8'd1;
    end
    if (c >= usable_cols()) begin
      c = usable_cols() - 8'd1;
    end
    addr = (r == '0) ? c : (RowOneBase + c);
    return make_byte(CmdSetAddr | addr, 1'b0);
  endfunction

  // Work out the transfers one accepted request causes and queue them.
  task automatic plan_request(input clcd_pkg::req_t r);
    clcd_pkg::rsp_t             run[$];
    clcd_pkg::rsp_t             tail;
    logic [clcd_pkg::ByteW-1:0] w;
    w = usable_cols();
    unique case (r.cmd)
      clcd_pkg::CMD_INIT: begin
        run.push_back(make_xfer(clcd_pkg::XFER_WAIT, 1'b0, '0, clcd_pkg::SettlePowerUp));
        run.push_back(make_xfer(clcd_pkg::XFER_NIBBLE, 1'b0, clcd_pkg::NibbleWake,
                                clcd_pkg::SettleLong));
        run.push_back(make_xfer(clcd_pkg::XFER_NIBBLE, 1'b0, clcd_pkg::NibbleWake,
                                clcd_pkg::SettleNibble));
        run.push_back(make_xfer(clcd_pkg::XFER_NIBBLE, 1'b0, clcd_pkg::NibbleWake,
                                clcd_pkg::SettleNibble));
        run.push_back(make_xfer(clcd_pkg::XFER_NIBBLE, 1'b0, clcd_pkg::NibbleFour,
                                clcd_pkg::SettleNibble));
        run.push_back(make_byte(clcd_pkg::ByteFuncSet, 1'b0));
        run.push_back(make_byte(clcd_pkg::ByteDispOn, 1'b0));
        run.push_back(make_byte(clcd_pkg::ByteClear, 1'b0));
        run.push_back(make_byte(clcd_pkg::ByteEntryMode, 1'b0));
      end
      clcd_pkg::CMD_CLEAR:      run.push_back(make_byte(clcd_pkg::ByteClear, 1'b0));
      clcd_pkg::CMD_ON:         run.push_back(make_byte(clcd_pkg::ByteDispOn, 1'b0));
      clcd_pkg::CMD_OFF:        run.push_back(make_byte(clcd_pkg::ByteDispOff, 1'b0));
      clcd_pkg::CMD_SET_CURSOR: run.push_back(make_cursor(r.row_index, r.column_index));
      clcd_pkg::CMD_PUT_CHAR:   run.push_back(make_byte(r.char_code, 1'b1));
      clcd_pkg::CMD_LINE_BEGIN: begin
        run.push_back(make_cursor(r.row_index, '0));
        shadow_line_pos = '0;
      end
      clcd_pkg::CMD_LINE_CHAR: begin
        // Characters past the current width are dropped.
        if (shadow_line_pos < w) begin
          run.push_back(make_byte(r.char_code, 1'b1));
          shadow_line_pos = shadow_line_pos + clcd_pkg::LineColW'(1);
        end
      end
      clcd_pkg::CMD_LINE_END: begin
        // Pad the rest of the line with spaces.
        while (shadow_line_pos < w) begin
          run.push_back(make_byte(clcd_pkg::ByteSpace, 1'b1));
          shadow_line_pos = shadow_line_pos + clcd_pkg::LineColW'(1);
        end
      end
      default: begin
      end
    endcase
    if (run.size() > 0) begin
      tail = run.pop_back();
      tail.last_of_run = 1'b1;
      run.push_back(tail);
    end
    foreach (run[i]) begin
      pending_xfers.push_back(run[i]);
    end
  endtask

  task automatic report_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
    mismatches++;
  endtask

  // Compare each result transaction against the oldest expected transfer,
  // then track configuration writes and accepted requests.
  always @(posedge clk_i or negedge rst_ni) begin
    clcd_pkg::rsp_t want;
    if (!rst_ni) begin
      shadow_cols     = clcd_pkg::ResetCols;
      shadow_rows     = clcd_pkg::ResetRows;
      shadow_line_pos = '0;
      pending_xfers.delete();
      mismatches      = 0;
      pending_o      <= 0;
    end else begin
      if (pop_i && !empty_i) begin
        if (pending_xfers.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual 0x%0h", $time, rsp_i);
          mismatches++;
        end else begin
          want = pending_xfers.pop_front();
          if (rsp_i.transfer_kind !== want.transfer_kind) begin
            report_field("transfer_kind", 32'(want.transfer_kind), 32'(rsp_i.transfer_kind));
          end
          if (rsp_i.reg_select !== want.reg_select) begin
            report_field("reg_select", 32'(want.reg_select), 32'(rsp_i.reg_select));
          end
          if (rsp_i.bus_value !== want.bus_value) begin
            report_field("bus_value", 32'(want.bus_value), 32'(rsp_i.bus_value));
          end
          if (rsp_i.settle_us !== want.settle_us) begin
            report_field("settle_us", 32'(want.settle_us), 32'(rsp_i.settle_us));
          end
          if (rsp_i.last_of_run !== want.last_of_run) begin
            report_field("last_of_run", 32'(want.last_of_run), 32'(rsp_i.last_of_run));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          clcd_pkg::RegColumns: shadow_cols = cfg_data_i;
          clcd_pkg::RegRows:    shadow_rows = cfg_data_i;
          default: begin
          end
        endcase
      end
      if (push_i && !full_i) begin
        plan_request(req_i);
      end
      pending_o <= pending_xfers.size();
    end
  end

endmodule

/* bench/char_lcd_4bit_command_sequencer_tb.sv */
module char_lcd_4bit_command_sequencer_tb;

  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned DrainCycles   = 64;
  localparam int unsigned HoldCycles    = 400;
  localparam int unsigned Segments      = 8;
  localparam int unsigned SegmentItems  = 18;
  localparam logic [clcd_pkg::CfgIndexW-1:0] RegUnused    = 4'hF;
  localparam logic [clcd_pkg::CmdW-1:0]      CmdBogusLow  = 4'd9;
  localparam logic [clcd_pkg::CmdW-1:0]      CmdBogusHigh = 4'd15;

  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           push        = 1'b0;
  logic                           full;
  clcd_pkg::req_t                 req_i       = '0;
  logic                           empty;
  logic                           pop         = 1'b0;
  clcd_pkg::rsp_t                 rsp_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [clcd_pkg::CfgIndexW-1:0] cfg_index_i = '0;
  logic [clcd_pkg::ByteW-1:0]     cfg_data_i  = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 26;
  int unsigned recv_idle_pct = 62;
  bit          hold_off_request = 1'b0;

  always #10 clk_i = ~clk_i;

  char_lcd_4bit_command_sequencer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .req_i       (req_i),
    .empty       (empty),
    .pop         (pop),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  char_lcd_transfer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_i       (full),
    .req_i        (req_i),
    .empty_i      (empty),
    .pop_i        (pop),
    .rsp_i        (rsp_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side: random stalls, and one long hold-off when asked for.
  always begin
    @(posedge clk_i);
    if (hold_off_request) begin
      pop <= 1'b0;
      repeat (HoldCycles) @(posedge clk_i);
      hold_off_request = 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic clcd_pkg::req_t make_req(input logic [clcd_pkg::CmdW-1:0] cmd,
                                              input logic [clcd_pkg::ByteW-1:0] row,
                                              input logic [clcd_pkg::ByteW-1:0] col,
                                              input logic [clcd_pkg::ByteW-1:0] ch);
    clcd_pkg::req_t r;
    r.cmd          = cmd;
    r.row_index    = row;
    r.column_index = col;
    r.char_code    = ch;
    return r;
  endfunction

  // Offer one request and hold it until the transaction completes.
  task automatic send_req(input clcd_pkg::req_t r);
    if ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    push  <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
  endtask

  // Stop offering, wait for every owed transfer, then let the engine go quiet.
  task automatic drain();
    push <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [clcd_pkg::CfgIndexW-1:0] idx,
                           input logic [clcd_pkg::ByteW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Stimulus and verdict.
  initial begin
    int unsigned                sent;
    int unsigned                nchars;
    int unsigned                pick;
    logic [clcd_pkg::ByteW-1:0] seg_cols;
    logic [clcd_pkg::ByteW-1:0] seg_rows;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, first at the reset size of 16 by 2.
    send_req(make_req(clcd_pkg::CMD_INIT, 8'h00, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_SET_CURSOR, 8'hFF, 8'hFF, 8'hFF));
    drain();
    write_reg(clcd_pkg::RegColumns, 8'd5);
    write_reg(clcd_pkg::RegRows, 8'd4);
    send_req(make_req(clcd_pkg::CMD_CLEAR, 8'h00, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_ON, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(clcd_pkg::CMD_OFF, 8'h00, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_SET_CURSOR, 8'h00, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_SET_CURSOR, 8'hFF, 8'hFF, 8'h00));
    send_req(make_req(clcd_pkg::CMD_SET_CURSOR, 8'd2, 8'd1, 8'h00));
    send_req(make_req(clcd_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, 8'hFF));
    send_req(make_req(clcd_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, clcd_pkg::ByteClear));
    send_req(make_req(clcd_pkg::CMD_PUT_CHAR, 8'h00, 8'h00, clcd_pkg::ByteHome));
    // A full line plus one character that gets clipped, then nothing to pad.
    send_req(make_req(clcd_pkg::CMD_LINE_BEGIN, 8'h00, 8'hFF, 8'h00));
    for (int i = 0; i < 6; i++) begin
      send_req(make_req(clcd_pkg::CMD_LINE_CHAR, 8'h00, 8'h00, 8'h41 + 8'(i)));
    end
    send_req(make_req(clcd_pkg::CMD_LINE_END, 8'h00, 8'h00, 8'h00));
    // Short line on a clamped row, padded with spaces.
    send_req(make_req(clcd_pkg::CMD_LINE_BEGIN, 8'hFF, 8'h00, 8'h00));
    send_req(make_req(clcd_pkg::CMD_LINE_CHAR, 8'h00, 8'h00, clcd_pkg::ByteHome));
    send_req(make_req(clcd_pkg::CMD_LINE_END, 8'h00, 8'h00, 8'h00));
    // Unknown commands are ignored.
    send_req(make_req(CmdBogusLow, 8'hFF, 8'hFF, 8'hFF));
    send_req(make_req(CmdBogusHigh, 8'h00, 8'h00, 8'h00));

    // Random part, one display size per segment.
    for (int seg = 0; seg < Segments; seg++) begin
      drain();
      unique case (seg)
        0: begin seg_cols = 8'd0;   seg_rows = 8'd0;   end
        1: begin seg_cols = 8'd1;   seg_rows = 8'd4;   end
        2: begin seg_cols = 8'd40;  seg_rows = 8'd1;   end
        3: begin seg_cols = 8'd41;  seg_rows = 8'd5;   end
        4: begin seg_cols = 8'd255; seg_rows = 8'd255; end
        5: begin seg_cols = 8'd7;   seg_rows = 8'd3;   end
        6: begin
          seg_cols = 8'($urandom_range(255));
          seg_rows = 8'($urandom_range(255));
        end
        default: begin
          seg_cols = 8'($urandom_range(1, 40));
          seg_rows = 8'($urandom_range(1, 4));
        end
      endcase
      write_reg(clcd_pkg::RegColumns, seg_cols);
      write_reg(clcd_pkg::RegRows, seg_rows);
      if (seg == 3) begin
        write_reg(RegUnused, 8'($urandom_range(255)));
      end
      if (seg < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 62;
      end else if (seg < 6) begin
        send_idle_pct = 62;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      if (seg == 6) begin
        hold_off_request = 1'b1;
      end

      sent = 0;
      while (sent < SegmentItems) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          // Streamed line, sometimes cut short without its end.
          send_req(make_req(clcd_pkg::CMD_LINE_BEGIN,
                            8'($urandom_range(255) >> $urandom_range(7)),
                            8'($urandom_range(255)), 8'($urandom_range(255))));
          nchars = ($urandom_range(4) == 0) ? $urandom_range(44) : $urandom_range(8);
          for (int i = 0; i < nchars; i++) begin
            send_req(make_req(clcd_pkg::CMD_LINE_CHAR, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
          end
          sent += nchars + 1;
          if ($urandom_range(4) != 0) begin
            send_req(make_req(clcd_pkg::CMD_LINE_END, 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255))));
            sent++;
          end
        end else if (pick < 92) begin
          send_req(make_req(4'($urandom_range(clcd_pkg::CMD_LINE_END)),
                            8'($urandom_range(255) >> $urandom_range(7)),
                            8'($urandom_range(255) >> $urandom_range(7)),
                            8'($urandom_range(255))));
          sent++;
        end else begin
          send_req(make_req(4'($urandom_range(CmdBogusHigh, CmdBogusLow)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255))));
        end
      end
    end

    drain();
    if ((fail_count == 0) && (pending == 0)) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/clcd_pkg.sv
sv/clcd_fifo.sv
sv/clcd_front.sv
sv/clcd_back.sv
sv/char_lcd_4bit_command_sequencer.sv
bench/char_lcd_transfer_checker.sv
bench/char_lcd_4bit_command_sequencer_tb.sv
